[rtl/softmax_normalizer_top_defines.svh]
// Assertion macros shared by the softmax normalizer RTL.
`ifndef SOFTMAX_NORMALIZER_TOP_DEFINES_SVH
`define SOFTMAX_NORMALIZER_TOP_DEFINES_SVH
`ifndef SYNTH
`define SMN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SMN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SMN_ASSERT_IMP(lbl, ante, cons, msg)
`define SMN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/smn_pkg.sv]
// Types, constants and table function of the softmax normalizer.
package smn_pkg;

  localparam int unsigned MAX_LEN_DEF        = 64;
  localparam int unsigned EXP_TABLE_BITS_DEF = 8;

  localparam int unsigned CNT_W     = 7;   // holds a count up to 64
  localparam int unsigned SUM_W     = 23;  // up to 64 * 2^16
  localparam int unsigned LNQ_W     = 12;
  localparam int unsigned DIV_STEPS = 17;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [63:0] LN2_Q32   = 64'd2977044472;

  localparam logic REG_OUTPUT_MODE = 1'b0;

  typedef struct packed {
    logic               bank;
    logic [CNT_W-1:0]   cnt;
    logic signed [15:0] max;
    logic               dropped;
    logic               mode;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_EXP,
    S_LNPREP,
    S_LNSRCH,
    S_LNMUL,
    S_DIV,
    S_OUT
  } back_state_e;

  // 2^(k/2^bits) - 1 in Q0.16, from a 25-term integer series, rounded and capped.
  function automatic logic [15:0] frac_entry(input int unsigned k, input int unsigned bits);
    logic [127:0] x;
    logic [127:0] term;
    logic [127:0] acc;
    logic [127:0] r;
    x    = (128'(k) * 128'(LN2_Q32)) >> bits;
    term = 128'(1) << 32;
    acc  = term;
    for (int unsigned j = 1; j <= 24; j++) begin
      term = ((term * x) >> 32) / 128'(j);
      acc  = acc + term;
    end
    r = (acc + 128'd32768) >> 16;
    if (r >= 128'd65536) begin
      r = r - 128'd65536;
    end else begin
      r = '0;
    end
    if (r > 128'd65535) begin
      r = 128'd65535;
    end
    return r[15:0];
  endfunction

endpackage

[rtl/softmax_normalizer_top.sv]
// Load: 1 cycle per element; every item stalls while the job queue holds two closed vectors.
// Exp-sum pass: start, then S_RD, S_MUL, S_EXP per element; mode 1 then finds ln of the sum.
// Normalize pass per element: S_RD, S_MUL, S_EXP, 17-step serial divider (mode 0), S_OUT.
// Two banks in the element RAM let one vector load while the previous one is processed.
// Reset (rst_ni low, asynchronous) clears count, maximum, flags, queues and output_mode.
module softmax_normalizer_top #(
  parameter int unsigned MAX_LEN        = smn_pkg::MAX_LEN_DEF,
  parameter int unsigned EXP_TABLE_BITS = smn_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] loglik_i,
  input  logic               last_in_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [16:0] value_o,
  output logic               last_out_o,
  output logic               overflow_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IDX_W = $clog2(MAX_LEN);

  logic                  mode_q;
  logic                  ram_we;
  logic [IDX_W:0]        ram_waddr;
  logic [15:0]           ram_wdata;
  logic [IDX_W:0]        ram_raddr;
  logic [15:0]           ram_rdata;
  logic                  jq_push;
  logic                  jq_full;
  logic                  jq_pop;
  logic                  jq_valid;
  smn_pkg::job_t         jq_in;
  smn_pkg::job_t         jq_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == smn_pkg::REG_OUTPUT_MODE) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == smn_pkg::REG_OUTPUT_MODE)) begin
      mode_q <= pwdata[0];
    end
  end

  smn_front #(
    .MAX_LEN (MAX_LEN),
    .IDX_W   (IDX_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .loglik_i    (loglik_i),
    .last_in_i   (last_in_i),
    .mode_i      (mode_q),
    .jobq_full_i (jq_full),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .job_push_o  (jq_push),
    .job_o       (jq_in)
  );

  smn_ram #(
    .WIDTH (16),
    .DEPTH (2 << IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  smn_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jq_push),
    .job_i   (jq_in),
    .full_o  (jq_full),
    .pop_i   (jq_pop),
    .valid_o (jq_valid),
    .job_o   (jq_head)
  );

  smn_back #(
    .MAX_LEN        (MAX_LEN),
    .EXP_TABLE_BITS (EXP_TABLE_BITS),
    .IDX_W          (IDX_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (jq_valid),
    .job_i       (jq_head),
    .job_pop_o   (jq_pop),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .pop_i       (pop),
    .empty_o     (empty),
    .value_o     (value_o),
    .last_out_o  (last_out_o),
    .overflow_o  (overflow_o)
  );

endmodule

[rtl/smn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module smn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/smn_front.sv]
// Load side: stores elements, tracks maximum, count and drop flag, issues jobs.
`include "softmax_normalizer_top_defines.svh"
module smn_front #(
  parameter int unsigned MAX_LEN = smn_pkg::MAX_LEN_DEF,
  parameter int unsigned IDX_W   = $clog2(MAX_LEN)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic signed [15:0] loglik_i,
  input  logic               last_in_i,
  input  logic               mode_i,
  input  logic               jobq_full_i,
  output logic               ram_we_o,
  output logic [IDX_W:0]     ram_waddr_o,
  output logic [15:0]        ram_wdata_o,
  output logic               job_push_o,
  output smn_pkg::job_t      job_o
);

  logic                         bank_q, bank_d;
  logic [smn_pkg::CNT_W-1:0]    count_q, count_d;
  logic signed [15:0]           max_q, max_d;
  logic                         drop_q, drop_d;
  logic                         accept;
  logic                         store;
  logic [smn_pkg::CNT_W-1:0]    new_count;
  logic signed [15:0]           new_max;
  logic                         new_drop;

  assign full_o = jobq_full_i;
  assign accept = push_i && !full_o;
  assign store  = count_q < smn_pkg::CNT_W'(MAX_LEN);

  assign new_count = count_q + smn_pkg::CNT_W'(store);
  assign new_max   = (store && (loglik_i > max_q)) ? loglik_i : max_q;
  assign new_drop  = drop_q || !store;

  assign ram_we_o    = accept && store;
  assign ram_waddr_o = {bank_q, count_q[IDX_W-1:0]};
  assign ram_wdata_o = loglik_i;

  assign job_push_o    = accept && last_in_i;
  assign job_o.bank    = bank_q;
  assign job_o.cnt     = new_count;
  assign job_o.max     = new_max;
  assign job_o.dropped = new_drop;
  assign job_o.mode    = mode_i;

  always_comb begin
    bank_d  = bank_q;
    count_d = count_q;
    max_d   = max_q;
    drop_d  = drop_q;
    if (accept) begin
      if (last_in_i) begin
        // vector closed: hand it over and start the next one in the other bank
        bank_d  = !bank_q;
        count_d = '0;
        max_d   = 16'sh8000;
        drop_d  = 1'b0;
      end else begin
        count_d = new_count;
        max_d   = new_max;
        drop_d  = new_drop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= 1'b0;
      count_q <= '0;
      max_q   <= 16'sh8000;
      drop_q  <= 1'b0;
    end else begin
      bank_q  <= bank_d;
      count_q <= count_d;
      max_q   <= max_d;
      drop_q  <= drop_d;
    end
  end

  `SMN_ASSERT_IMP(a_count_bound, 1'b1, count_q <= smn_pkg::CNT_W'(MAX_LEN), "count past MAX_LEN")
  `SMN_ASSERT_NEXT(a_drop_sticky, accept && !store && !last_in_i, drop_q, "drop flag lost")

endmodule

[rtl/smn_jobq.sv]
// Two-entry job queue between the load side and the compute side.
module smn_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  smn_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output smn_pkg::job_t job_o
);

  smn_pkg::job_t entry_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    fill_q;
  logic          do_push;
  logic          do_pop;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign job_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fill_q <= fill_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[rtl/smn_back.sv]
// Compute side: exp-sum pass, ln of the sum, normalize pass and result register.
`include "softmax_normalizer_top_defines.svh"
module smn_back #(
  parameter int unsigned MAX_LEN        = smn_pkg::MAX_LEN_DEF,
  parameter int unsigned EXP_TABLE_BITS = smn_pkg::EXP_TABLE_BITS_DEF,
  parameter int unsigned IDX_W          = $clog2(MAX_LEN)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  smn_pkg::job_t       job_i,
  output logic                job_pop_o,
  output logic [IDX_W:0]      ram_raddr_o,
  input  logic [15:0]         ram_rdata_i,
  input  logic                pop_i,
  output logic                empty_o,
  output logic signed [16:0]  value_o,
  output logic                last_out_o,
  output logic                overflow_o
);

  localparam int unsigned B      = EXP_TABLE_BITS;
  localparam int unsigned TAB_N  = 1 << B;
  localparam int unsigned PROD_W = 33;
  localparam int unsigned P_W    = PROD_W - (24 - B);
  localparam int unsigned N_W    = P_W - B;
  localparam int unsigned LN_W   = B + 20;
  localparam int unsigned BIT_W  = (B > 1) ? $clog2(B) : 1;
  localparam int unsigned CW     = smn_pkg::CNT_W;
  localparam int unsigned SW     = smn_pkg::SUM_W;

  typedef logic [15:0] frac_tab_t [TAB_N];

  function automatic frac_tab_t build_tab();
    frac_tab_t t;
    for (int unsigned k = 0; k < TAB_N; k++) begin
      t[k] = smn_pkg::frac_entry(k, B);
    end
    return t;
  endfunction

  localparam frac_tab_t FracTab = build_tab();

  smn_pkg::back_state_e     state_q, state_d;
  logic                     pass_q, pass_d;
  logic [CW-1:0]            i_q, i_d;
  logic [SW-1:0]            sum_q, sum_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  logic [15:0]              u_q, u_d;
  logic [2:0]               lm_q, lm_d;
  logic [B-1:0]             k_q, k_d;
  logic [BIT_W-1:0]         bit_q, bit_d;
  logic [smn_pkg::LNQ_W-1:0] lnq_q, lnq_d;
  logic [SW-1:0]            rem_q, rem_d;
  logic [16:0]              quo_q, quo_d;
  logic [16:0]              lo_q, lo_d;
  logic [4:0]               step_q, step_d;
  logic [16:0]              res_q, res_d;

  logic                     out_valid_q;
  logic [16:0]              out_value_q;
  logic                     out_last_q;
  logic                     out_ovf_q;
  logic                     out_load;
  logic                     out_free;

  // exp of the registered product
  logic [P_W-1:0]           p;
  logic [N_W-1:0]           n;
  logic [B-1:0]             f;
  logic [N_W:0]             sh;
  logic [B-1:0]             tab_idx;
  logic [16:0]              mant;
  logic [16:0]              e;
  logic [32:0]              dvd;

  logic [15:0]              u_c;
  logic [B-1:0]             trial_k;
  logic [LN_W-1:0]          ln_prod;
  logic [SW:0]              trial;
  logic                     ge;
  logic [16:0]              q_fin;
  logic signed [17:0]       v_log;
  logic [2:0]               lm_c;
  logic [SW-1:0]            mant_ln;
  logic                     is_last;

  assign p       = prod_q[PROD_W-1:24-B];
  assign n       = p[P_W-1:B];
  assign f       = p[B-1:0];
  assign sh      = {1'b0, n} + (N_W+1)'(f != '0);
  assign tab_idx = (~f) + 1'b1;
  assign mant    = (f == '0) ? 17'h10000 : 17'h10000 + {1'b0, FracTab[tab_idx]};
  assign e       = (sh > (N_W+1)'(17)) ? 17'd0 : mant >> sh[4:0];
  assign dvd     = {e, 16'd0} - {16'd0, e};

  assign u_c     = 16'(job_i.max - $signed(ram_rdata_i));
  assign trial_k = k_q | B'(1 << bit_q);
  assign ln_prod = LN_W'({lm_q, k_q}) * LN_W'(smn_pkg::LN2_Q16) + LN_W'(1 << (7 + B));
  assign trial   = {rem_q, lo_q[16]};
  assign ge      = trial >= {1'b0, sum_q};
  assign q_fin   = {quo_q[15:0], ge};
  assign v_log   = -$signed({2'b0, u_q}) - $signed({6'b0, lnq_q});
  assign mant_ln = sum_q >> lm_q;
  assign is_last = (i_q + 1'b1) == job_i.cnt;
  assign out_free = !out_valid_q || pop_i;

  always_comb begin
    lm_c = '0;
    for (int b = 0; b < 7; b++) begin
      if (sum_q[16+b]) begin
        lm_c = 3'(b);
      end
    end
  end

  assign ram_raddr_o = {job_i.bank, i_q[IDX_W-1:0]};

  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    i_d       = i_q;
    sum_d     = sum_q;
    prod_d    = prod_q;
    u_d       = u_q;
    lm_d      = lm_q;
    k_d       = k_q;
    bit_d     = bit_q;
    lnq_d     = lnq_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    lo_d      = lo_q;
    step_d    = step_q;
    res_d     = res_q;
    out_load  = 1'b0;
    job_pop_o = 1'b0;
    unique case (state_q)
      smn_pkg::S_IDLE: begin
        if (job_valid_i) begin
          pass_d  = 1'b0;
          i_d     = '0;
          sum_d   = '0;
          state_d = smn_pkg::S_RD;
        end
      end
      smn_pkg::S_RD: begin
        state_d = smn_pkg::S_MUL;
      end
      smn_pkg::S_MUL: begin
        u_d     = u_c;
        prod_d  = PROD_W'(u_c) * PROD_W'(smn_pkg::LOG2E_Q16);
        state_d = smn_pkg::S_EXP;
      end
      smn_pkg::S_EXP: begin
        if (!pass_q) begin
          sum_d = sum_q + SW'(e);
          if (is_last) begin
            i_d     = '0;
            pass_d  = 1'b1;
            state_d = job_i.mode ? smn_pkg::S_LNPREP : smn_pkg::S_RD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = smn_pkg::S_RD;
          end
        end else if (job_i.mode) begin
          // saturate below at the most negative Q8.8 value
          res_d   = (v_log < -18'sd32768) ? 17'h18000 : 17'(v_log);
          state_d = smn_pkg::S_OUT;
        end else begin
          rem_d   = SW'(dvd[32:17]);
          lo_d    = dvd[16:0];
          quo_d   = '0;
          step_d  = 5'(smn_pkg::DIV_STEPS);
          state_d = smn_pkg::S_DIV;
        end
      end
      smn_pkg::S_LNPREP: begin
        lm_d    = lm_c;
        k_d     = '0;
        bit_d   = BIT_W'(B - 1);
        state_d = smn_pkg::S_LNSRCH;
      end
      smn_pkg::S_LNSRCH: begin
        if (FracTab[trial_k] <= mant_ln[15:0]) begin
          k_d = trial_k;
        end
        if (bit_q == '0) begin
          state_d = smn_pkg::S_LNMUL;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      smn_pkg::S_LNMUL: begin
        lnq_d   = ln_prod[smn_pkg::LNQ_W+8+B-1:8+B];
        state_d = smn_pkg::S_RD;
      end
      smn_pkg::S_DIV: begin
        rem_d  = ge ? SW'(trial - {1'b0, sum_q}) : SW'(trial);
        lo_d   = {lo_q[15:0], 1'b0};
        quo_d  = q_fin;
        step_d = step_q - 1'b1;
        if (step_q == 5'd1) begin
          res_d   = q_fin[16] ? 17'h0ffff : q_fin;
          state_d = smn_pkg::S_OUT;
        end
      end
      smn_pkg::S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (is_last) begin
            job_pop_o = 1'b1;
            state_d   = smn_pkg::S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = smn_pkg::S_RD;
          end
        end
      end
      default: state_d = smn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smn_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (out_valid_q && !pop_i) || out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q <= pass_d;
    i_q    <= i_d;
    sum_q  <= sum_d;
    prod_q <= prod_d;
    u_q    <= u_d;
    lm_q   <= lm_d;
    k_q    <= k_d;
    bit_q  <= bit_d;
    lnq_q  <= lnq_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    lo_q   <= lo_d;
    step_q <= step_d;
    res_q  <= res_d;
    if (out_load) begin
      out_value_q <= res_q;
      out_last_q  <= is_last;
      out_ovf_q   <= job_i.dropped;
    end
  end

  assign empty_o    = !out_valid_q;
  assign value_o    = $signed(out_value_q);
  assign last_out_o = out_last_q;
  assign overflow_o = out_ovf_q;

  `SMN_ASSERT_IMP(a_job_held, state_q != smn_pkg::S_IDLE, job_valid_i, "job left while busy")
  `SMN_ASSERT_IMP(a_idx_range, state_q == smn_pkg::S_RD, i_q < job_i.cnt, "read past vector")
  `SMN_ASSERT_IMP(a_div_nonzero, state_q == smn_pkg::S_DIV, sum_q != '0, "divide by zero sum")
  `SMN_ASSERT_NEXT(a_pop_on_last, out_load && is_last, state_q == smn_pkg::S_IDLE, "no idle")

endmodule

[tb/tb_softmax_normalizer_top.sv]
// Self-checking testbench for the softmax normalizer: directed and random vectors in both modes.
`timescale 1ns / 100ps

module tb_softmax_normalizer_top;

  typedef struct packed {
    logic signed [16:0] value;
    logic               last;
    logic               ovf;
  } norm_result_t;

  localparam int unsigned TAB_SIZE = 256;
  localparam logic [2:0] ADDR_MODE = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] loglik_i = '0;
  logic               last_in_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [16:0] value_o;
  logic               last_out_o;
  logic               overflow_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  softmax_normalizer_top dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  int unsigned  frac_tab[TAB_SIZE];
  logic [15:0]  vec_store[64];
  int unsigned  vec_count;
  int           vec_max;
  bit           vec_dropped;
  bit           mode_q;
  norm_result_t pending_results[$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned mismatches;

  function automatic void build_frac_tab();
    longint unsigned x, term, acc, r;
    for (int unsigned k = 0; k < TAB_SIZE; k++) begin
      x = (longint'(k) * 64'd2977044472) / TAB_SIZE;
      term = 64'd1 << 32;
      acc = term;
      for (int unsigned j = 1; j <= 24; j++) begin
        term = ((term * x) >> 32) / j;
        acc += term;
      end
      r = (acc + 32768) >> 16;
      r = (r >= 65536) ? r - 65536 : 0;
      if (r > 65535) r = 65535;
      frac_tab[k] = int'(r);
    end
  endfunction

  function automatic int unsigned exp_of_neg(int unsigned u);
    longint unsigned p, n, sh;
    int unsigned f, mant;
    p = (longint'(u) * 94548) >> 16;
    n = p >> 8;
    f = int'(p & 255);
    if (f == 0) begin
      mant = 65536;
      sh = n;
    end else begin
      mant = 65536 + frac_tab[TAB_SIZE - f];
      sh = n + 1;
    end
    if (sh > 17) return 0;
    return mant >> sh;
  endfunction

  function automatic int unsigned ln_of_sum(int unsigned sum);
    int unsigned lead, frac, best;
    longint unsigned mant, lg;
    lead = 16;
    best = 0;
    for (int unsigned b = 16; b < 32; b++) begin
      if (sum[b]) lead = b;
    end
    mant = (longint'(sum) << 16) >> lead;
    frac = (mant >= 65536) ? int'(mant - 65536) : 0;
    for (int unsigned k = 0; k < TAB_SIZE; k++) begin
      if (frac_tab[k] <= frac) best = k;
    end
    lg = longint'(lead - 16) * TAB_SIZE + best;
    return int'((lg * 45426 + (64'd1 << 15)) >> 16);
  endfunction

  // fold one accepted element into the vector; on last, queue its normalized results
  function automatic void absorb_element(logic signed [15:0] x, bit last);
    int unsigned sum, lnq, u;
    longint v;
    norm_result_t r;
    if (vec_count < 64) begin
      vec_store[vec_count] = x;
      vec_count++;
      if (int'(x) > vec_max) vec_max = int'(x);
    end else begin
      vec_dropped = 1'b1;
    end
    if (!last) return;
    sum = 0;
    for (int unsigned i = 0; i < vec_count; i++) begin
      sum += exp_of_neg(vec_max - int'($signed(vec_store[i])));
    end
    lnq = mode_q ? ln_of_sum(sum) : 0;
    for (int unsigned i = 0; i < vec_count; i++) begin
      u = vec_max - int'($signed(vec_store[i]));
      if (!mode_q) begin
        v = (sum != 0) ? longint'((longint'(exp_of_neg(u)) * 65535) / sum) : 0;
        if (v > 65535) v = 65535;
      end else begin
        v = -longint'(u) - longint'(lnq);
        if (v < -32768) v = -32768;
      end
      r.value = v[16:0];
      r.last = (i + 1 == vec_count);
      r.ovf = vec_dropped;
      pending_results.push_back(r);
    end
    vec_count = 0;
    vec_max = -32768;
    vec_dropped = 1'b0;
  endfunction

  task automatic send_element(logic signed [15:0] x, bit last);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    push <= 1'b1;
    loglik_i <= x;
    last_in_i <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    absorb_element(x, last);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_MODE) mode_q = data[0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // hold the sender until every queued result is out, then let the pipeline drain
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_mode(bit mode);
    wait_drained();
    reg_write(ADDR_MODE, ($urandom & 32'hffff_fffe) | 32'(mode));
  endtask

  task automatic send_vector(int unsigned len, bit narrow);
    logic signed [15:0] base, x;
    int unsigned spread;
    base = 16'($urandom);
    spread = $urandom_range(1, 2048);
    for (int unsigned i = 0; i < len; i++) begin
      x = narrow ? 16'(base + $urandom_range(0, spread)) : 16'($urandom);
      send_element(x, i + 1 == len);
    end
  endtask

  task automatic test_directed();
    for (int m = 0; m < 2; m++) begin
      set_mode(m[0]);
      send_element(16'sh7fff, 1'b1);
      send_element(-16'sd32768, 1'b0);
      send_element(16'sh7fff, 1'b1);
      send_element(16'sd0, 1'b0);
      send_element(16'sd0, 1'b0);
      send_element(16'sd0, 1'b1);
      send_element(16'sd256, 1'b0);
      send_element(-16'sd256, 1'b0);
      send_element(16'sd1, 1'b1);
    end
    // unused register index must not disturb the mode
    wait_drained();
    reg_write(ADDR_UNUSED, 32'hffff_ffff);
    send_element(-16'sd5, 1'b0);
    send_element(-16'sd700, 1'b1);
  endtask

  task automatic test_truncation();
    set_mode(1'b0);
    send_vector(64, 1'b1);
    send_vector(66, 1'b1);
    set_mode(1'b1);
    send_vector(65, 1'b0);
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned sent, len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) set_mode(1'($urandom_range(1)));
      len = ($urandom_range(11) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
      send_vector(len, $urandom_range(3) != 0);
      sent += len;
    end
  endtask

  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    norm_result_t exp_r;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%0d", value_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (value_o !== exp_r.value || last_out_o !== exp_r.last
            || overflow_o !== exp_r.ovf) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp value=%0d last=%0b ovf=%0b, got value=%0d last=%0b ovf=%0b",
                     exp_r.value, exp_r.last, exp_r.ovf, value_o, last_out_o, overflow_o);
          end
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    build_frac_tab();
    vec_count = 0;
    vec_max = -32768;
    vec_dropped = 1'b0;
    mode_q = 1'b0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_truncation();
    test_random(30);
    idle_pct = 85;
    test_random(30);
    idle_pct = 0;
    stall_pct = 85;
    test_random(30);
    idle_pct = 6;
    stall_pct = 6;
    test_random(30);
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/smn_pkg.sv
rtl/smn_ram.sv
rtl/smn_front.sv
rtl/smn_jobq.sv
rtl/smn_back.sv
rtl/softmax_normalizer_top.sv
tb/tb_softmax_normalizer_top.sv
